// ===== design/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
// No dependencies; imported by the controller, datapath and top level.
package tccw_pkg;

	localparam int OP_W    = 1;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int CELL_W  = 16;
	localparam int CROW_W  = 5;
	localparam int CCOL_W  = 7;
	localparam int COLOR_W = 8;

	localparam logic [OP_W-1:0]    OP_PUT       = 1'b0;
	localparam logic [OP_W-1:0]    OP_READ      = 1'b1;
	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
	localparam logic [CELL_W-1:0]  BLANK_RESET  = 16'h0720;
	localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_FILL   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // latch a request from the input ports
		logic clear;   // write one blank cell of the power-up clearing pass
		logic access;  // cell write or read, cursor update
		logic fill;    // write one blank cell of the scrolled-in row
		logic load;    // move the result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic scroll;
		logic fill_last;
	} sts_t;

endpackage

// ===== design/tccw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/tccw_ctrl.sv =====
// Controller state machine for the text console character writer.
// Depends on tccw_pkg; drives the datapath through cmd_t, watches sts_t.
module tccw_ctrl
	import tccw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = in_valid && in_ready;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.access = (state_q == ST_ACCESS);
		cmd.fill   = (state_q == ST_FILL);
		cmd.load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.accept) state_d = ST_ACCESS;
			end
			ST_ACCESS: begin
				state_d = sts.scroll ? ST_FILL : ST_DONE;
			end
			ST_FILL: begin
				if (sts.fill_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (cmd.load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/tccw_dp.sv =====
// Datapath: screen store (circular row buffer), cursor, color and result registers.
// Depends on tccw_pkg and tccw_ram; commanded by tccw_ctrl.
module tccw_dp
	import tccw_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_wr_en,
	input  logic [COLOR_W-1:0] cfg_wr_data,
	input  logic [OP_W-1:0]    op,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [INDEX_W-1:0] cell_index,
	output logic [CELL_W-1:0]  cell_value,
	output logic [CROW_W-1:0]  cursor_row,
	output logic [CCOL_W-1:0]  cursor_col,
	output logic               scrolled
);

	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);

	logic [COLOR_W-1:0] text_color_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  row_base_q;   // row_q * COLS, logical
	logic [ADDR_W-1:0]  top_base_q;   // physical start of logical row 0
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [COL_W-1:0]   fill_cnt_q;
	logic [ADDR_W-1:0]  fill_base_q;

	logic [OP_W-1:0]    op_q;
	logic [CHAR_W-1:0]  char_q;
	logic               in_range_q;
	logic [ADDR_W-1:0]  phys_q;
	logic [CELL_W-1:0]  value_q;
	logic               scrolled_q;

	logic [CELL_W-1:0]  cell_value_q;
	logic [CROW_W-1:0]  cursor_row_q;
	logic [CCOL_W-1:0]  cursor_col_q;
	logic               scrolled_out_q;

	logic               idx_in_range;
	logic [ADDR_W-1:0]  logical;
	logic [ADDR_W:0]    phys_sum;
	logic [ADDR_W-1:0]  phys;

	logic               is_put, is_nl, wrap_col, last_row;
	logic [CELL_W-1:0]  word;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic [CELL_W-1:0]  ram_rdata;

	// logical cell address -> physical, rotated by the scroll offset
	assign idx_in_range = (32'(cell_index) < CELLS);
	always_comb begin
		if (op == OP_READ) begin
			logical = idx_in_range ? ADDR_W'(cell_index) : '0;
		end else begin
			logical = row_base_q + ADDR_W'(col_q);
		end
		phys_sum = {1'b0, logical} + {1'b0, top_base_q};
		if (phys_sum >= (ADDR_W+1)'(CELLS)) begin
			phys = ADDR_W'(phys_sum - (ADDR_W+1)'(CELLS));
		end else begin
			phys = phys_sum[ADDR_W-1:0];
		end
	end

	assign is_put   = (op_q == OP_PUT);
	assign is_nl    = (char_q == NEWLINE_CODE);
	assign wrap_col = is_nl || (col_q == COL_W'(COLS - 1));
	assign last_row = (row_q == ROW_W'(ROWS - 1));
	assign word     = {text_color_q, char_q};

	assign sts.clear_last = (clr_cnt_q == ADDR_W'(CELLS - 1));
	assign sts.scroll     = is_put && wrap_col && last_row;
	assign sts.fill_last  = (fill_cnt_q == COL_W'(COLS - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys_q;
		ram_wdata = word;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = BLANK_RESET;
		end else if (cmd.fill) begin
			ram_we    = 1'b1;
			ram_waddr = fill_base_q + ADDR_W'(fill_cnt_q);
			ram_wdata = {text_color_q, SPACE_CODE};
		end else if (cmd.access && is_put && !is_nl) begin
			ram_we = 1'b1;
		end
	end

	tccw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (phys_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
			row_q        <= '0;
			col_q        <= '0;
			row_base_q   <= '0;
			top_base_q   <= '0;
			clr_cnt_q    <= '0;
			fill_cnt_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				text_color_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.fill) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (cmd.access) begin
				fill_cnt_q <= '0;
				if (is_put) begin
					if (wrap_col) begin
						col_q <= '0;
						if (last_row) begin
							// old top row becomes the new bottom row
							if (top_base_q == ADDR_W'(CELLS - COLS)) begin
								top_base_q <= '0;
							end else begin
								top_base_q <= top_base_q + ADDR_W'(COLS);
							end
						end else begin
							row_q      <= row_q + 1'b1;
							row_base_q <= row_base_q + ADDR_W'(COLS);
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= op;
			char_q     <= char_code;
			in_range_q <= (op == OP_PUT) || idx_in_range;
			phys_q     <= phys;
		end
		if (cmd.access) begin
			value_q     <= (is_put && !is_nl) ? word : '0;
			scrolled_q  <= sts.scroll;
			fill_base_q <= top_base_q;
		end
		if (cmd.load) begin
			if (op_q == OP_READ) begin
				cell_value_q <= in_range_q ? ram_rdata : '0;
			end else begin
				cell_value_q <= value_q;
			end
			cursor_row_q   <= CROW_W'(row_q);
			cursor_col_q   <= CCOL_W'(col_q);
			scrolled_out_q <= scrolled_q;
		end
	end

	assign cell_value = cell_value_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign scrolled   = scrolled_out_q;

endmodule

// ===== design/text_console_char_writer.sv =====
// Text console character writer: ROWS x COLS screen of 16-bit cells with a cursor.
// A taken request passes the ACCESS and DONE states, then its result enters the output
// register; no new request is taken until then. A put that scrolls also passes FILL,
// which blanks the new bottom row in the screen RAM (rows are kept as a circular buffer,
// so no rows are copied). A finished result waits while the output register is full and
// not read; no request is taken meanwhile. After reset a clearing pass blanks every cell.
module text_console_char_writer
	import tccw_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COLOR_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    op,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [INDEX_W-1:0] cell_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CELL_W-1:0]  cell_value,
	output logic [CROW_W-1:0]  cursor_row,
	output logic [CCOL_W-1:0]  cursor_col,
	output logic               scrolled
);

	cmd_t cmd;
	sts_t sts;

	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tccw_dp #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.char_code   (char_code),
		.cell_index  (cell_index),
		.cell_value  (cell_value),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col),
		.scrolled    (scrolled)
	);

	// at most one datapath command per cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.clear, cmd.access, cmd.fill, cmd.load}))
		else $error("overlapping datapath commands");

	a_accept_access: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.access)
		else $error("accepted request not processed next cycle");

	a_scroll_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.access && sts.scroll) |=> cmd.fill)
		else $error("scroll did not start row fill");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded result not presented");

endmodule
